// ----- rtl/vvb_pkg.sv -----
// types and constants for the velocity verlet body step block
// no dependencies
package vvb_pkg;

    localparam int unsigned REG_W     = 17;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MASS_W    = 31;
    localparam int unsigned DT_W      = 21;
    localparam logic [REG_W-1:0] DECAY_RESET = 17'd655;
    localparam logic [REG_W-1:0] DEAD_RESET  = 17'd13107;

    localparam logic REG_DECAY = 1'b0;
    localparam logic REG_DEAD  = 1'b1;

    typedef struct packed {
        logic                      active;
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
        logic signed [DATA_W-1:0]  vel_x;
        logic signed [DATA_W-1:0]  vel_y;
        logic signed [DATA_W-1:0]  force_x;
        logic signed [DATA_W-1:0]  force_y;
        logic [MASS_W-1:0]         mass;
        logic [DT_W-1:0]           dt;
    } t_body_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic signed [DATA_W-1:0] new_force_x;
        logic signed [DATA_W-1:0] new_force_y;
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
    } t_body_out;

    typedef struct packed {
        logic [REG_W-1:0] decay;
        logic [REG_W-1:0] dead;
    } t_cfg;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/velocity_verlet_body_step_2d_top.sv -----
// channel  | signals                         | beat taken when
// in       | i_start, o_busy, i_body         | i_start && !o_busy
// out      | o_done, o_result                | o_done (one cycle, no stall)
// cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid && ready
// one body per cycle; each passes FRAC_BITS + 32 divider stages, one divider
// output stage, then four integration stages. o_busy is only high in reset.
// reset restores both registers to their defaults and clears all valid bits.
// uses vvb_pkg, vvb_div, vvb_integ
module velocity_verlet_body_step_2d_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  vvb_pkg::t_body_in  i_body,
    output logic               o_done,
    output vvb_pkg::t_body_out o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import vvb_pkg::*;

    localparam int unsigned TAG_W = 1 + 4 * DATA_W + DT_W;
    localparam int unsigned INTEG_LAT = 4;

    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay <= DECAY_RESET;
            r_cfg.dead  <= DEAD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DECAY: r_cfg.decay <= i_cfg_data;
                REG_DEAD:  r_cfg.dead  <= i_cfg_data;
                default:   r_cfg.decay <= r_cfg.decay;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;
    assign o_busy      = !i_rst_n;

    logic in_v;
    assign in_v = i_start && !o_busy;

    // x divider tags along active, pos, vel and dt; y divider tags along the forces
    logic [TAG_W-1:0] tag_in, tag_x;
    logic [63:0]      tag_y;
    assign tag_in = {i_body.active, i_body.pos_x, i_body.pos_y,
                     i_body.vel_x, i_body.vel_y, i_body.dt};

    logic dv_x, dv_y;
    logic signed [31:0] acc_x, acc_y;

    vvb_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div_x (
        .i_clk, .i_rst_n, .i_valid(in_v), .i_force(i_body.force_x),
        .i_mass(i_body.mass), .i_tag(tag_in),
        .o_valid(dv_x), .o_acc(acc_x), .o_tag(tag_x)
    );
    vvb_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(64)) u_div_y (
        .i_clk, .i_rst_n, .i_valid(in_v), .i_force(i_body.force_y),
        .i_mass(i_body.mass), .i_tag({i_body.force_x, i_body.force_y}),
        .o_valid(dv_y), .o_acc(acc_y), .o_tag(tag_y)
    );

    logic               t_act;
    logic signed [31:0] t_px, t_py, t_vx, t_vy, t_fx, t_fy;
    logic [20:0]        t_dt;
    assign {t_act, t_px, t_py, t_vx, t_vy, t_dt} = tag_x;
    assign {t_fx, t_fy} = tag_y;

    vvb_integ #(.FRAC_BITS(FRAC_BITS)) u_ix (
        .i_clk, .i_acc(acc_x), .i_pos(t_px), .i_vel(t_vx),
        .i_force(t_fx), .i_dt(t_dt), .i_active(t_act), .i_cfg(r_cfg),
        .o_pos(o_result.new_pos_x), .o_vel(o_result.new_vel_x),
        .o_force(o_result.new_force_x), .o_acc(o_result.acc_x)
    );
    vvb_integ #(.FRAC_BITS(FRAC_BITS)) u_iy (
        .i_clk, .i_acc(acc_y), .i_pos(t_py), .i_vel(t_vy),
        .i_force(t_fy), .i_dt(t_dt), .i_active(t_act), .i_cfg(r_cfg),
        .o_pos(o_result.new_pos_y), .o_vel(o_result.new_vel_y),
        .o_force(o_result.new_force_y), .o_acc(o_result.acc_y)
    );

    logic [INTEG_LAT-1:0] r_vpipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[INTEG_LAT-2:0], dv_x && dv_y};
        end
    end
    assign o_done = r_vpipe[INTEG_LAT-1];
endmodule

// ----- rtl/vvb_div.sv -----
// pipelined restoring divider: one quotient bit per stage, one item per cycle
// uses vvb_pkg; quotient of (|force| << FRAC_BITS) by mass, saturated to 32-bit acc
module vvb_div #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned TAG_W     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [31:0]            i_force,
    input  logic [30:0]                   i_mass,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_valid,
    output logic signed [31:0]            o_acc,
    output logic [TAG_W-1:0]              o_tag
);
    import vvb_pkg::*;

    localparam int unsigned NW = 32 + FRAC_BITS;   // dividend width
    localparam int unsigned RW = 32;               // remainder width (mass < 2^31)

    logic              r_v   [NW+1];
    logic [NW-1:0]     r_num [NW+1];
    logic [RW-1:0]     r_rem [NW+1];
    logic [30:0]       r_den [NW+1];
    logic              r_neg [NW+1];
    logic              r_zero[NW+1];
    logic [TAG_W-1:0]  r_tag [NW+1];

    logic              r_ov;
    logic signed [31:0] r_acc;
    logic [TAG_W-1:0]  r_otag;

    logic [31:0] mag;
    assign mag = i_force[31] ? 32'(-i_force) : 32'(i_force);

    always_comb begin
        r_v[0]    = i_valid;
        r_num[0]  = {mag, {FRAC_BITS{1'b0}}};
        r_rem[0]  = '0;
        r_den[0]  = i_mass;
        r_neg[0]  = i_force[31];
        r_zero[0] = (mag == 32'd0);
        r_tag[0]  = i_tag;
    end

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [RW:0]   trial;
        logic [RW-1:0] shifted;
        assign shifted = {r_rem[g][RW-2:0], r_num[g][NW-1]};
        assign trial   = {1'b0, shifted} - {2'b0, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_rem[g+1]  <= trial[RW] ? shifted : trial[RW-1:0];
            r_num[g+1]  <= {r_num[g][NW-2:0], ~trial[RW]};
            r_den[g+1]  <= r_den[g];
            r_neg[g+1]  <= r_neg[g];
            r_zero[g+1] <= r_zero[g];
            r_tag[g+1]  <= r_tag[g];
        end
    end

    // sign and saturation stage; mass is never zero per contract but handle it
    logic [NW-1:0] q;
    logic signed [31:0] n_acc;
    assign q = r_num[NW];
    always_comb begin
        if (r_zero[NW]) begin
            n_acc = '0;
        end else if (r_den[NW] == '0) begin
            n_acc = r_neg[NW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (r_neg[NW]) begin
            n_acc = (q > NW'(33'h8000_0000)) ? 32'sh8000_0000 : 32'(-q);
        end else begin
            n_acc = (q > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NW];
        end
        r_acc  <= n_acc;
        r_otag <= r_tag[NW];
    end

    assign o_valid = r_ov;
    assign o_acc   = r_acc;
    assign o_tag   = r_otag;
endmodule

// ----- rtl/vvb_integ.sv -----
// per-axis integration after the divider: half step, position, velocity,
// force decay and dead band; uses vvb_pkg, four register stages
module vvb_integ #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic signed [31:0]       i_acc,
    input  logic signed [31:0]       i_pos,
    input  logic signed [31:0]       i_vel,
    input  logic signed [31:0]       i_force,
    input  logic [20:0]              i_dt,
    input  logic                     i_active,
    input  vvb_pkg::t_cfg            i_cfg,
    output logic signed [31:0]       o_pos,
    output logic signed [31:0]       o_vel,
    output logic signed [31:0]       o_force,
    output logic signed [31:0]       o_acc
);
    import vvb_pkg::*;

    // stage 1: acc * dt
    logic signed [53:0] r1_prod;
    logic signed [31:0] r1_acc, r1_pos, r1_vel, r1_force;
    logic [20:0]        r1_dt;
    logic               r1_act;
    always_ff @(posedge i_clk) begin
        r1_prod  <= i_acc * $signed({1'b0, i_dt});
        r1_acc   <= i_acc;
        r1_pos   <= i_pos;
        r1_vel   <= i_vel;
        r1_force <= i_force;
        r1_dt    <= i_dt;
        r1_act   <= i_active;
    end

    // stage 2: half step and tmp velocity
    logic signed [53:0] half1;
    logic signed [31:0] tmp1;
    assign half1 = r1_prod >>> (FRAC_BITS + 1);
    assign tmp1  = sat32(64'(r1_vel) + 64'(half1));

    logic signed [53:0] r2_half;
    logic signed [31:0] r2_tmp, r2_acc, r2_pos, r2_force;
    logic [20:0]        r2_dt;
    logic               r2_act;
    logic signed [31:0] r2_vel;
    always_ff @(posedge i_clk) begin
        r2_half  <= half1;
        r2_tmp   <= tmp1;
        r2_acc   <= r1_acc;
        r2_pos   <= r1_pos;
        r2_vel   <= r1_vel;
        r2_force <= r1_force;
        r2_dt    <= r1_dt;
        r2_act   <= r1_act;
    end

    // stage 3: tmp * dt, new velocity, decayed force
    logic signed [63:0] f2;
    always_comb begin
        if (r2_force > 0) begin
            f2 = 64'(r2_force) - 64'(i_cfg.decay);
        end else if (r2_force < 0) begin
            f2 = 64'(r2_force) + 64'(i_cfg.decay);
        end else begin
            f2 = '0;
        end
    end

    logic signed [53:0] r3_prod;
    logic signed [31:0] r3_v2, r3_acc, r3_pos, r3_f2, r3_vel, r3_force;
    logic               r3_act;
    always_ff @(posedge i_clk) begin
        r3_prod  <= r2_tmp * $signed({1'b0, r2_dt});
        r3_v2    <= sat32(64'(r2_tmp) + 64'(r2_half));
        r3_f2    <= sat32(f2);
        r3_acc   <= r2_acc;
        r3_pos   <= r2_pos;
        r3_vel   <= r2_vel;
        r3_force <= r2_force;
        r3_act   <= r2_act;
    end

    // stage 4: position, dead band, pass-through select
    logic signed [31:0] db;
    logic               stop;
    logic signed [31:0] npos;
    assign db   = 32'(i_cfg.dead);
    assign stop = (r3_v2 < db) && (r3_v2 > -db);
    assign npos = sat32(64'(r3_pos) + 64'(r3_prod >>> FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (r3_act) begin
            o_pos   <= npos;
            o_vel   <= stop ? '0 : r3_v2;
            o_force <= stop ? '0 : r3_f2;
            o_acc   <= stop ? '0 : r3_acc;
        end else begin
            o_pos   <= r3_pos;
            o_vel   <= r3_vel;
            o_force <= r3_force;
            o_acc   <= '0;
        end
    end
endmodule

// ----- dv/tb_velocity_verlet_body_step_2d_top.sv -----
// self-checking testbench for velocity_verlet_body_step_2d_top
// predicts each body update in fixed point and checks every result beat
// depends on rtl/vvb_pkg.sv and the block rtl
module tb_velocity_verlet_body_step_2d_top;
    import vvb_pkg::*;

    localparam int FB = 16;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int LATENCY = FB + 32 + 1 + 4;

    class body_scoreboard;
        t_body_out expected_q[$];
        logic [REG_W-1:0] decay_step;
        logic [REG_W-1:0] dead_band;
        int n_bad;
        int n_checked;

        function new();
            decay_step = DECAY_RESET;
            dead_band  = DEAD_RESET;
            n_bad = 0;
            n_checked = 0;
        endfunction

        function void write_reg(logic idx, logic [REG_W-1:0] val);
            if (idx == REG_DECAY) begin
                decay_step = val;
            end else begin
                dead_band = val;
            end
        endfunction

        function longint clip32(longint v);
            if (v > S32_MAX) return S32_MAX;
            if (v < S32_MIN) return S32_MIN;
            return v;
        endfunction

        function void step_axis(longint pos, longint vel, longint frc, longint mass,
                                longint dt, output longint npos, output longint nvel,
                                output longint nfrc, output longint nacc);
            longint mag;
            longint q;
            longint acc;
            longint half;
            longint tmp;
            longint v2;
            longint f2;
            longint db;
            if (frc == 0) begin
                acc = 0;
            end else if (mass == 0) begin
                acc = (frc < 0) ? S32_MIN : S32_MAX;
            end else begin
                mag = (frc < 0) ? -frc : frc;
                q = (mag << FB) / mass;
                if (frc < 0) acc = (q > 64'sh8000_0000) ? S32_MIN : -q;
                else acc = (q > S32_MAX) ? S32_MAX : q;
            end
            half = (acc * dt) >>> (FB + 1);
            tmp  = clip32(vel + half);
            npos = clip32(pos + ((tmp * dt) >>> FB));
            v2   = clip32(tmp + half);
            if (frc > 0) f2 = frc - longint'(decay_step);
            else if (frc < 0) f2 = frc + longint'(decay_step);
            else f2 = 0;
            db = longint'(dead_band);
            // axis stops when speed is inside the dead band
            if (v2 < db && v2 > -db) begin
                v2 = 0;
                acc = 0;
                f2 = 0;
            end
            nvel = v2;
            nfrc = clip32(f2);
            nacc = acc;
        endfunction

        function void note_body(t_body_in b);
            t_body_out r;
            longint p, v, f, a;
            if (b.active) begin
                step_axis(longint'(b.pos_x), longint'(b.vel_x), longint'(b.force_x),
                          longint'(b.mass), longint'(b.dt), p, v, f, a);
                r.new_pos_x = 32'(p); r.new_vel_x = 32'(v);
                r.new_force_x = 32'(f); r.acc_x = 32'(a);
                step_axis(longint'(b.pos_y), longint'(b.vel_y), longint'(b.force_y),
                          longint'(b.mass), longint'(b.dt), p, v, f, a);
                r.new_pos_y = 32'(p); r.new_vel_y = 32'(v);
                r.new_force_y = 32'(f); r.acc_y = 32'(a);
            end else begin
                r.new_pos_x = b.pos_x;     r.new_pos_y = b.pos_y;
                r.new_vel_x = b.vel_x;     r.new_vel_y = b.vel_y;
                r.new_force_x = b.force_x; r.new_force_y = b.force_y;
                r.acc_x = 0;               r.acc_y = 0;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_body_out got);
            t_body_out exp_r;
            logic [DATA_W-1:0] e[8];
            logic [DATA_W-1:0] g[8];
            string names[8];
            names = '{"new_pos_x", "new_pos_y", "new_vel_x", "new_vel_y",
                      "new_force_x", "new_force_y", "acc_x", "acc_y"};
            if (expected_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("result beat with nothing expected: %h", got);
                return;
            end
            exp_r = expected_q.pop_front();
            n_checked++;
            e = '{exp_r.new_pos_x, exp_r.new_pos_y, exp_r.new_vel_x, exp_r.new_vel_y,
                  exp_r.new_force_x, exp_r.new_force_y, exp_r.acc_x, exp_r.acc_y};
            g = '{got.new_pos_x, got.new_pos_y, got.new_vel_x, got.new_vel_y,
                  got.new_force_x, got.new_force_y, got.acc_x, got.acc_y};
            foreach (e[i]) begin
                if (g[i] !== e[i]) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch result %0d %s: expected %h got %h",
                                 n_checked, names[i], e[i], g[i]);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    t_body_in i_body;
    logic o_done;
    t_body_out o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_index;
    logic [16:0] i_cfg_data;

    body_scoreboard sb;
    bit idle_on;
    int n_sent;

    velocity_verlet_body_step_2d_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_body(i_body), .o_done(o_done), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    task automatic send_body(t_body_in b);
        if (idle_on) begin
            while ($urandom_range(99) < 12) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_body  <= b;
        do @(posedge i_clk); while (o_busy);
        sb.note_body(b);
        n_sent++;
    endtask

    task automatic write_cfg(logic idx, logic [16:0] val);
        // registers only change once the pipeline has drained
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_body_in make_body(int kind);
        t_body_in b;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        b = raw[$bits(t_body_in)-1:0];
        case (kind)
            0: ; // raw bits across every field
            1: begin
                // plausible body: mass near one, short step, moderate motion
                b.active  = ($urandom_range(99) < 90);
                b.pos_x   = $signed($urandom) >>> $urandom_range(31);
                b.pos_y   = $signed($urandom) >>> $urandom_range(31);
                b.vel_x   = $signed($urandom) >>> $urandom_range(10, 30);
                b.vel_y   = $signed($urandom) >>> $urandom_range(10, 30);
                b.force_x = $signed($urandom) >>> $urandom_range(8, 30);
                b.force_y = $signed($urandom) >>> $urandom_range(8, 30);
                b.mass    = 31'($urandom_range(32768, 4 << 16));
                b.dt      = 21'($urandom_range(0, 1 << 16));
            end
            default: begin
                // slow bodies around the dead band and small forces
                b.active  = 1'b1;
                b.vel_x   = $signed($urandom_range(0, 40000)) - 20000;
                b.vel_y   = $signed($urandom_range(0, 40000)) - 20000;
                b.force_x = $signed($urandom_range(0, 4000)) - 2000;
                b.force_y = $signed($urandom_range(0, 4000)) - 2000;
                b.mass    = 31'($urandom_range(1, 1 << 18));
                b.dt      = 21'($urandom_range(0, 1 << 17));
            end
        endcase
        return b;
    endfunction

    task automatic run_random(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            idle_on = !(n_sent > 700 && n_sent < 1000);
            k = $urandom_range(99);
            send_body(make_body(k < 20 ? 0 : (k < 80 ? 1 : 2)));
        end
    endtask

    initial begin
        t_body_in b;
        int waited;
        sb = new();
        n_sent = 0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_body = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_DECAY;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners at reset settings
        b = make_body(1); b.active = 1'b0; send_body(b);
        b = make_body(1); b.pos_x = 32'(S32_MAX); b.pos_y = 32'(S32_MIN);
        b.vel_x = 32'(S32_MAX); b.vel_y = 32'(S32_MIN); b.dt = 21'h1FFFFF; send_body(b);
        b = make_body(1); b.force_x = 32'(S32_MAX); b.force_y = 32'(S32_MIN);
        b.mass = 31'd1; send_body(b);
        b = make_body(1); b.mass = 31'd0; send_body(b);
        b = make_body(1); b.mass = 31'd0; b.force_x = 0; b.force_y = -1; send_body(b);
        b = make_body(1); b.mass = 31'h7FFFFFFF; send_body(b);
        b = make_body(1); b.dt = 21'd0; send_body(b);
        b = make_body(1); b.dt = 21'h100000; send_body(b);
        b = make_body(1); b.force_x = 0; b.force_y = 0; send_body(b);
        b = make_body(1); b.vel_x = 100; b.vel_y = -13106; b.dt = 21'd0; send_body(b);
        b = make_body(1); b.vel_x = 13107; b.vel_y = -13107; b.dt = 21'd0; send_body(b);
        b = make_body(1); b.force_x = 10; b.force_y = -10; b.vel_x = 32'(S32_MAX);
        b.vel_y = 32'(S32_MIN); send_body(b);
        b = make_body(1); b.active = 1'b0; b.pos_x = 32'(S32_MIN);
        b.force_y = 32'(S32_MAX);
        send_body(b);
        b = '1; send_body(b);
        b = '0; b.active = 1'b1; send_body(b);

        run_random(377);
        write_cfg(REG_DECAY, 17'd0);
        write_cfg(REG_DEAD, 17'd0);
        run_random(377);
        write_cfg(REG_DECAY, 17'd65536);
        write_cfg(REG_DEAD, 17'd65536);
        run_random(377);
        write_cfg(REG_DECAY, 17'h1FFFF);
        write_cfg(REG_DEAD, 17'h1FFFF);
        run_random(377);
        write_cfg(REG_DECAY, 17'($urandom));
        write_cfg(REG_DEAD, 17'($urandom));
        run_random(377);
        i_start <= 1'b0;

        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d bodies over five register settings, %0d results checked",
                 n_sent, sb.n_checked);
        $display("mismatches: %0d, results still outstanding: %0d",
                 sb.n_bad, sb.expected_q.size());
        if (sb.n_bad == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/vvb_pkg.sv
rtl/vvb_div.sv
rtl/vvb_integ.sv
rtl/velocity_verlet_body_step_2d_top.sv
dv/tb_velocity_verlet_body_step_2d_top.sv
